// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent assertions of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/lca_pkg.sv =====
// ----------------------------------------------------------------------------
// LCA package
// Types and constants shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package lca_pkg;

	localparam int unsigned NODE_W  = 10;
	localparam int unsigned DEPTH_W = 10;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = 10'h3FF;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_REDUCE,
		S_L_DEP,
		S_L_WR0,
		S_L_RD,
		S_L_WR,
		S_Q_DEP,
		S_Q_SWAP,
		S_Q1_RD,
		S_Q1_UPD,
		S_Q_CHK,
		S_Q2_RD,
		S_Q2_UPD,
		S_Q_FIN_RD,
		S_Q_FIN
	} lca_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic red_step;
		logic rd_input;
		logic dep_wr;
		logic jmp_wr;
		logic jmp_wr_lvl0;
		logic mid_init;
		logic mid_load;
		logic lvl_clr;
		logic lvl_inc;
		logic lvl_dec;
		logic lvl_top;
		logic swap_load;
		logic lift_v;
		logic lift_vw;
		logic emit_v;
		logic emit_jmp;
	} lca_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic red_none;
		logic red_zero;
		logic lvl_single;
		logic ld_last;
		logic lvl_zero;
		logic meet;
	} lca_status_t;

endpackage

// ===== sv/lca_dp.sv =====
// ----------------------------------------------------------------------------
// LCA datapath
// Depth and ancestor memories, node registers, level counter and result.
// ----------------------------------------------------------------------------
module lca_dp #(
	parameter int NODES  = 1024,
	parameter int LEVELS = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lca_pkg::lca_cmd_t                 cmd,
	input  logic [lca_pkg::NODE_W-1:0]        first_node,
	input  logic [lca_pkg::NODE_W-1:0]        second_node,
	output lca_pkg::lca_status_t              status,
	output logic [lca_pkg::NODE_W-1:0]        ancestor,
	output logic                              done
);

	localparam int IW        = (NODES >= 1024) ? 10 : $clog2(NODES);
	localparam int LW        = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int JMP_DEPTH = NODES << LW;
	localparam int RED_STEPS = (NODES > 1023) ? 0 : $clog2(1023 / NODES + 1);
	localparam int RW        = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
	localparam logic [LW-1:0] LVL_TOP = LW'(LEVELS - 1);

	logic [lca_pkg::NODE_W-1:0]  a_q, b_q;
	logic [RW-1:0]               red_q;
	logic [31:0]                 red_sub;
	logic [IW-1:0]               a_idx, b_idx;
	logic [IW-1:0]               v_q, w_q;
	logic [lca_pkg::DEPTH_W-1:0] dw_q;
	logic [LW-1:0]               lvl_q;
	logic [LW-1:0]               jmp_wr_lvl;

	logic [lca_pkg::DEPTH_W-1:0] dep_mem [NODES];
	logic [IW-1:0]               jmp_mem [JMP_DEPTH];
	logic [lca_pkg::DEPTH_W-1:0] dep_rd_a_q, dep_rd_b_q;
	logic [IW-1:0]               jmp_rd_a_q, jmp_rd_b_q;
	logic [IW-1:0]               dep_addr_a, dep_addr_b;
	logic [lca_pkg::DEPTH_W-1:0] dep_wdata;
	logic [IW-1:0]               jmp_wdata;
	logic                        lift_ok;
	logic                        swap;

	logic [lca_pkg::NODE_W-1:0]  ancestor_q;
	logic                        done_q;

	// Node numbers wrap modulo NODES by restoring subtraction of NODES << j.
	assign red_sub = 32'(NODES) << red_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			a_q <= first_node;
			b_q <= second_node;
		end else if (cmd.red_step) begin
			if ({22'd0, a_q} >= red_sub) a_q <= 10'({22'd0, a_q} - red_sub);
			if ({22'd0, b_q} >= red_sub) b_q <= 10'({22'd0, b_q} - red_sub);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q <= '0;
		end else if (cmd.capture) begin
			red_q <= RW'(RED_STEPS - 1);
		end else if (cmd.red_step) begin
			red_q <= red_q - 1'b1;
		end
	end

	assign a_idx = a_q[IW-1:0];
	assign b_idx = b_q[IW-1:0];

	// Memory ports: two registered reads each, one write each.
	assign dep_addr_a = cmd.rd_input ? a_idx : v_q;
	assign dep_addr_b = cmd.rd_input ? b_idx : w_q;
	assign jmp_wr_lvl = cmd.jmp_wr_lvl0 ? '0 : lvl_q + 1'b1;

	always_comb begin
		if (a_idx == b_idx) begin
			dep_wdata = '0;
		end else if (dep_rd_b_q == lca_pkg::DEPTH_MAX) begin
			dep_wdata = lca_pkg::DEPTH_MAX;
		end else begin
			dep_wdata = dep_rd_b_q + 1'b1;
		end
	end

	assign jmp_wdata = cmd.jmp_wr_lvl0 ? b_idx : jmp_rd_a_q;

	always_ff @(posedge clk) begin
		if (cmd.dep_wr) dep_mem[a_idx] <= dep_wdata;
		dep_rd_a_q <= dep_mem[dep_addr_a];
		dep_rd_b_q <= dep_mem[dep_addr_b];
	end

	always_ff @(posedge clk) begin
		if (cmd.jmp_wr) jmp_mem[{a_idx, jmp_wr_lvl}] <= jmp_wdata;
		jmp_rd_a_q <= jmp_mem[{v_q, lvl_q}];
		jmp_rd_b_q <= jmp_mem[{w_q, lvl_q}];
	end

	// The deeper node is lifted by 2^level while it stays at or below the
	// other node's depth.
	assign lift_ok = ({7'd0, dep_rd_a_q} >= ({7'd0, dw_q} + (17'd1 << lvl_q)));
	assign swap    = dep_rd_a_q < dep_rd_b_q;

	always_ff @(posedge clk) begin
		priority if (cmd.swap_load) begin
			v_q  <= swap ? b_idx : a_idx;
			w_q  <= swap ? a_idx : b_idx;
			dw_q <= swap ? dep_rd_a_q : dep_rd_b_q;
		end else if (cmd.mid_init) begin
			v_q <= b_idx;
		end else if (cmd.mid_load) begin
			v_q <= jmp_rd_a_q;
		end else if (cmd.lift_v) begin
			if (lift_ok) v_q <= jmp_rd_a_q;
		end else if (cmd.lift_vw) begin
			if (jmp_rd_a_q != jmp_rd_b_q) begin
				v_q <= jmp_rd_a_q;
				w_q <= jmp_rd_b_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q <= '0;
		end else begin
			priority if (cmd.lvl_clr) begin
				lvl_q <= '0;
			end else if (cmd.lvl_top) begin
				lvl_q <= LVL_TOP;
			end else if (cmd.lvl_inc) begin
				lvl_q <= lvl_q + 1'b1;
			end else if (cmd.lvl_dec) begin
				lvl_q <= lvl_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_v) begin
			ancestor_q <= lca_pkg::NODE_W'(v_q);
		end else if (cmd.emit_jmp) begin
			ancestor_q <= lca_pkg::NODE_W'(jmp_rd_a_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit_v | cmd.emit_jmp;
		end
	end

	assign status.red_none   = (RED_STEPS == 0);
	assign status.red_zero   = (red_q == '0);
	assign status.lvl_single = (LEVELS == 1);
	assign status.ld_last    = ((32'(lvl_q) + 32'd1) == 32'(LEVELS - 1));
	assign status.lvl_zero   = (lvl_q == '0);
	assign status.meet       = (v_q == w_q);

	assign ancestor = ancestor_q;
	assign done     = done_q;

endmodule

// ===== sv/lca_ctrl.sv =====
// ----------------------------------------------------------------------------
// LCA controller
// Sequences node loads and ancestor queries over the datapath.
// ----------------------------------------------------------------------------
module lca_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 req_type,
	input  lca_pkg::lca_status_t status,
	output lca_pkg::lca_cmd_t    cmd,
	output logic                 busy
);

	lca_pkg::lca_state_t state_q, state_d;
	logic                is_query_q;
	logic                path_query;
	lca_pkg::lca_state_t path_first;

	assign path_query = (state_q == lca_pkg::S_IDLE) ? (req_type == lca_pkg::REQ_QUERY)
	                                                  : is_query_q;
	assign path_first = path_query ? lca_pkg::S_Q_DEP : lca_pkg::S_L_DEP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lca_pkg::S_IDLE;
			is_query_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == lca_pkg::S_IDLE && start) is_query_q <= path_query;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lca_pkg::S_IDLE: begin
				if (start) state_d = status.red_none ? path_first : lca_pkg::S_REDUCE;
			end
			lca_pkg::S_REDUCE: begin
				if (status.red_zero) state_d = path_first;
			end
			lca_pkg::S_L_DEP:    state_d = lca_pkg::S_L_WR0;
			lca_pkg::S_L_WR0: begin
				state_d = status.lvl_single ? lca_pkg::S_IDLE : lca_pkg::S_L_RD;
			end
			lca_pkg::S_L_RD:     state_d = lca_pkg::S_L_WR;
			lca_pkg::S_L_WR: begin
				state_d = status.ld_last ? lca_pkg::S_IDLE : lca_pkg::S_L_RD;
			end
			lca_pkg::S_Q_DEP:    state_d = lca_pkg::S_Q_SWAP;
			lca_pkg::S_Q_SWAP:   state_d = lca_pkg::S_Q1_RD;
			lca_pkg::S_Q1_RD:    state_d = lca_pkg::S_Q1_UPD;
			lca_pkg::S_Q1_UPD: begin
				state_d = status.lvl_zero ? lca_pkg::S_Q_CHK : lca_pkg::S_Q1_RD;
			end
			lca_pkg::S_Q_CHK: begin
				state_d = status.meet ? lca_pkg::S_IDLE : lca_pkg::S_Q2_RD;
			end
			lca_pkg::S_Q2_RD:    state_d = lca_pkg::S_Q2_UPD;
			lca_pkg::S_Q2_UPD: begin
				state_d = status.lvl_zero ? lca_pkg::S_Q_FIN_RD : lca_pkg::S_Q2_RD;
			end
			lca_pkg::S_Q_FIN_RD: state_d = lca_pkg::S_Q_FIN;
			lca_pkg::S_Q_FIN:    state_d = lca_pkg::S_IDLE;
			default:             state_d = lca_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			lca_pkg::S_IDLE: begin
				busy        = 1'b0;
				cmd.capture = start;
			end
			lca_pkg::S_REDUCE: cmd.red_step = 1'b1;
			lca_pkg::S_L_DEP:  cmd.rd_input = 1'b1;
			lca_pkg::S_L_WR0: begin
				cmd.dep_wr      = 1'b1;
				cmd.jmp_wr      = 1'b1;
				cmd.jmp_wr_lvl0 = 1'b1;
				cmd.mid_init    = 1'b1;
				cmd.lvl_clr     = 1'b1;
			end
			lca_pkg::S_L_RD: begin
			end
			lca_pkg::S_L_WR: begin
				cmd.jmp_wr   = 1'b1;
				cmd.mid_load = 1'b1;
				cmd.lvl_inc  = 1'b1;
			end
			lca_pkg::S_Q_DEP: cmd.rd_input = 1'b1;
			lca_pkg::S_Q_SWAP: begin
				cmd.swap_load = 1'b1;
				cmd.lvl_top   = 1'b1;
			end
			lca_pkg::S_Q1_RD: begin
			end
			lca_pkg::S_Q1_UPD: begin
				cmd.lift_v  = 1'b1;
				cmd.lvl_dec = !status.lvl_zero;
			end
			lca_pkg::S_Q_CHK: begin
				cmd.emit_v  = status.meet;
				cmd.lvl_top = !status.meet;
			end
			lca_pkg::S_Q2_RD: begin
			end
			lca_pkg::S_Q2_UPD: begin
				cmd.lift_vw = 1'b1;
				cmd.lvl_dec = !status.lvl_zero;
			end
			lca_pkg::S_Q_FIN_RD: begin
			end
			lca_pkg::S_Q_FIN: cmd.emit_jmp = 1'b1;
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

// ===== sv/lowest_common_ancestor.sv =====
// ----------------------------------------------------------------------------
// Lowest common ancestor engine
// Binary-lifting LCA over a rooted tree loaded one node at a time.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A load request
// (req_type 0) names a node in first_node and its parent in second_node; the
// root is loaded as its own parent, and a parent must be loaded before any of
// its children. A query request (req_type 1) names two nodes and produces one
// result: ancestor is valid for exactly one cycle while done is high, and the
// receiver must take it in that cycle because the block cannot hold it. Loads
// produce no result. Node numbers wrap modulo NODES. With NODES below 1024 the
// request first takes a reduction step for each shift j with NODES << j at
// most 1023 (none at the default size). A load then reads the parent's depth,
// writes the depth and the parent entry, then reads and writes the ancestor
// memory once for each higher level, since every level depends on the level
// below it. A query reads both depths, orders the nodes by depth and lifts
// the deeper one level by level; if the two then meet, one is an ancestor of
// the other. Otherwise a second pass lifts both and a last ancestor read
// gives the result. Each lifting pass spends a memory read and an update per
// level on the registered-read ancestor memory. Busy drops in the cycle the
// result appears, so a new request can enter then. The memories power up
// undefined; querying a node that was never loaded gives an undefined answer.
// ----------------------------------------------------------------------------
module lowest_common_ancestor #(
	parameter int NODES  = 1024,
	parameter int LEVELS = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       req_type,
	input  logic [lca_pkg::NODE_W-1:0] first_node,
	input  logic [lca_pkg::NODE_W-1:0] second_node,
	output logic                       done,
	output logic [lca_pkg::NODE_W-1:0] ancestor
);

	lca_pkg::lca_cmd_t    cmd;
	lca_pkg::lca_status_t status;

	// The controller walks the levels; the datapath holds both tables and
	// does the lifting compares.
	lca_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.status   (status),
		.cmd      (cmd),
		.busy     (busy)
	);

	lca_dp #(
		.NODES  (NODES),
		.LEVELS (LEVELS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.first_node  (first_node),
		.second_node (second_node),
		.status      (status),
		.ancestor    (ancestor),
		.done        (done)
	);

endmodule

// ===== sv/lca_checker.sv =====
// ----------------------------------------------------------------------------
// LCA port checker
// Concurrent checks on the request and result ports of the LCA engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lca_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// An accepted request keeps the engine busy in the following cycle.
	`CHK_ASSERT(a_accept_busy, clk, arst_n, start && !busy |=> busy, "request not held busy")

	// A result only appears as a request finishes.
	`CHK_ASSERT(a_done_ends_busy, clk, arst_n, done |-> !busy && $past(busy), "stray result")

	// Each result is a single-cycle strobe.
	`CHK_ASSERT(a_done_pulse, clk, arst_n, done |=> !done, "result repeated")

	// Reset leaves the engine idle with no result pending.
	`CHK_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> !busy && !done, "not idle in reset")

endmodule

bind lowest_common_ancestor lca_checker u_lca_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
